// File: rtl/core/otfe_pkg.sv
// Package for the order table fill engine: sizes, codes, payload and control types.
package otfe_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [IDX_W:0]   cnt_t;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_FILL   = 2'd1,
    MODE_FIND   = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_FULL    = 3'd2,
    ST_NOMATCH = 3'd3,
    ST_PARTIAL = 3'd4,
    ST_REMAIN  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_DONE = 2'd2
  } state_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] order_id;
    logic [15:0] party_id;
    logic [15:0] instrument_id;
    logic [31:0] price;
    logic [31:0] quantity;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] remainder;
    logic [15:0] entry_party;
    logic [15:0] entry_instrument;
    logic [31:0] entry_price;
    logic [31:0] size_before;
    logic [31:0] size_after;
  } rsp_t;

  typedef struct packed {
    logic [31:0] order_id;
    logic [15:0] party;
    logic [15:0] instrument;
    logic [31:0] price;
    logic [31:0] size;
  } slot_t;

  typedef struct packed {
    logic wr_en;
    logic vld_set;
    logic vld_clr;
    idx_t addr;
  } store_wr_t;

endpackage

// File: rtl/core/order_table_fill_engine_core.sv
// Order table fill engine top level: request sequencer, slot scan and result register.
//
// Usage:
//   A request is transferred at a rising edge with start high and busy low.
//   busy stays high while the request scans the table, one slot per cycle,
//   from slot 0 upward through the registered read port of the slot memory.
//   A fill, find or remove stops at the first valid slot with the order id;
//   an add scans every slot for a duplicate and the lowest free slot unless
//   a duplicate stops it early.
//   The next request may be transferred in the cycle the result is shown.
//   The result appears on out_rsp for exactly one cycle with out_valid high;
//   the receiver cannot stall it and must take it in that cycle.
//   Reset (rst_n low, synchronous) empties the table and aborts any request.
module order_table_fill_engine_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  otfe_pkg::req_t in_req,
  output logic           out_valid,
  output otfe_pkg::rsp_t out_rsp
);
  import otfe_pkg::*;

  localparam idx_t LAST_IDX = idx_t'(TABLE_ENTRIES - 1);
  localparam cnt_t END_CNT  = cnt_t'(TABLE_ENTRIES);

  state_t    state_r, state_nxt;
  req_t      req_r, req_nxt;
  cnt_t      scan_addr_r, scan_addr_nxt;
  idx_t      cmp_idx_r, cmp_idx_nxt;
  logic      pv_r, pv_nxt;
  logic      hit_r, hit_nxt;
  idx_t      hit_idx_r, hit_idx_nxt;
  slot_t     ent_r, ent_nxt;
  logic      free_found_r, free_found_nxt;
  idx_t      free_idx_r, free_idx_nxt;
  logic      out_valid_r, out_valid_nxt;
  rsp_t      out_rsp_r, out_rsp_nxt;

  slot_t     rd_entry;
  logic      rd_valid;
  store_wr_t wr_ctl;
  slot_t     wr_entry;

  logic        eval;
  logic        key_match;
  logic        hit_now;
  logic        last_now;
  logic [32:0] diff;

  otfe_slot_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (scan_addr_r[IDX_W-1:0]),
    .rd_entry (rd_entry),
    .rd_valid (rd_valid),
    .wr_ctl   (wr_ctl),
    .wr_entry (wr_entry)
  );

  assign eval = (state_r == S_SCAN) && pv_r;

  always_comb begin
    if (req_r.mode == MODE_ADD) begin
      key_match = (rd_entry.party == req_r.party_id) &&
                  (rd_entry.instrument == req_r.instrument_id) &&
                  (rd_entry.size == req_r.quantity) &&
                  (rd_entry.price == req_r.price);
    end else begin
      key_match = (rd_entry.order_id == req_r.order_id);
    end
  end

  assign hit_now  = eval && rd_valid && key_match;
  assign last_now = eval && (cmp_idx_r == LAST_IDX);
  assign diff     = {1'b0, ent_r.size} - {1'b0, req_r.quantity};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (hit_now || last_now) state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    req_nxt        = req_r;
    scan_addr_nxt  = scan_addr_r;
    cmp_idx_nxt    = cmp_idx_r;
    pv_nxt         = pv_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    ent_nxt        = ent_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    out_valid_nxt  = 1'b0;
    out_rsp_nxt    = out_rsp_r;
    wr_ctl         = '0;
    wr_entry       = ent_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt        = in_req;
          scan_addr_nxt  = '0;
          pv_nxt         = 1'b0;
          hit_nxt        = 1'b0;
          free_found_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        if (scan_addr_r != END_CNT) begin
          scan_addr_nxt = scan_addr_r + cnt_t'(1);
          cmp_idx_nxt   = scan_addr_r[IDX_W-1:0];
          pv_nxt        = 1'b1;
        end else begin
          pv_nxt = 1'b0;
        end
        if (hit_now) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = cmp_idx_r;
          ent_nxt     = rd_entry;
        end else if (eval && !rd_valid && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = cmp_idx_r;
        end
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        out_rsp_nxt   = '0;
        wr_ctl.addr   = hit_idx_r;
        if (req_r.mode == MODE_ADD) begin
          if (hit_r) begin
            out_rsp_nxt.status = ST_DUP;
          end else if (free_found_r) begin
            out_rsp_nxt.status = ST_OK;
            wr_ctl.wr_en       = 1'b1;
            wr_ctl.vld_set     = 1'b1;
            wr_ctl.addr        = free_idx_r;
            wr_entry.order_id   = req_r.order_id;
            wr_entry.party      = req_r.party_id;
            wr_entry.instrument = req_r.instrument_id;
            wr_entry.price      = req_r.price;
            wr_entry.size       = req_r.quantity;
          end else begin
            out_rsp_nxt.status = ST_FULL;
          end
        end else if (!hit_r) begin
          out_rsp_nxt.status = ST_NOMATCH;
        end else begin
          out_rsp_nxt.entry_party      = ent_r.party;
          out_rsp_nxt.entry_instrument = ent_r.instrument;
          out_rsp_nxt.entry_price      = ent_r.price;
          out_rsp_nxt.size_before      = ent_r.size;
          out_rsp_nxt.status           = ST_OK;
          case (req_r.mode)
            MODE_FILL: begin
              if (diff == 33'd0) begin
                wr_ctl.vld_clr = 1'b1;
              end else if (!diff[32]) begin
                out_rsp_nxt.status     = ST_PARTIAL;
                out_rsp_nxt.size_after = diff[31:0];
                wr_ctl.wr_en           = 1'b1;
                wr_entry.size          = diff[31:0];
              end else begin
                out_rsp_nxt.status    = ST_REMAIN;
                out_rsp_nxt.remainder = 32'd0 - diff[31:0];
                wr_ctl.vld_clr        = 1'b1;
              end
            end
            MODE_FIND: begin
              out_rsp_nxt.size_after = ent_r.size;
            end
            MODE_REMOVE: begin
              wr_ctl.vld_clr = 1'b1;
            end
            default: begin
              out_rsp_nxt.status = ST_NOMATCH;
            end
          endcase
        end
      end
      default: begin
        pv_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pv_r         <= 1'b0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
      scan_addr_r  <= '0;
    end else begin
      state_r      <= state_nxt;
      pv_r         <= pv_nxt;
      hit_r        <= hit_nxt;
      free_found_r <= free_found_nxt;
      out_valid_r  <= out_valid_nxt;
      scan_addr_r  <= scan_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    ent_r      <= ent_nxt;
    free_idx_r <= free_idx_nxt;
    out_rsp_r  <= out_rsp_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

// File: rtl/core/otfe_slot_store.sv
// Slot store: order memory with registered read port and per-slot valid flags.
module otfe_slot_store (
  input  logic              clk,
  input  logic              rst_n,
  input  otfe_pkg::idx_t    rd_addr,
  output otfe_pkg::slot_t   rd_entry,
  output logic              rd_valid,
  input  otfe_pkg::store_wr_t wr_ctl,
  input  otfe_pkg::slot_t   wr_entry
);
  import otfe_pkg::*;

  slot_t                    mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;
  slot_t                    rd_entry_r;
  logic                     rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_ctl.wr_en) begin
      mem[wr_ctl.addr] <= wr_entry;
    end
    rd_entry_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= valid_r[rd_addr];
      if (wr_ctl.vld_set) begin
        valid_r[wr_ctl.addr] <= 1'b1;
      end
      if (wr_ctl.vld_clr) begin
        valid_r[wr_ctl.addr] <= 1'b0;
      end
    end
  end

  assign rd_entry = rd_entry_r;
  assign rd_valid = rd_valid_r;

endmodule

// File: rtl/core/otfe_checker.sv
// Port-level checker for the order table fill engine, bound to the top level.
module otfe_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           start,
  input logic           busy,
  input logic           out_valid,
  input otfe_pkg::rsp_t out_rsp
);
  import otfe_pkg::*;

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("outputs active after reset");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after request transfer");

  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.status == ST_NOMATCH) |->
      (out_rsp.remainder == 32'd0) && (out_rsp.size_before == 32'd0) &&
      (out_rsp.size_after == 32'd0))
    else $error("no-match result carries nonzero fields");

endmodule

bind order_table_fill_engine_core otfe_checker u_otfe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);
